[rtl/wrd_pkg.sv]
// Package: shared types, widths, constants and calendar functions for the return-date unit.
`default_nettype none
package wrd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int WDAY_W  = 3;
  localparam int COUNT_W = 15;
  localparam int PROD_W  = 29;
  localparam int DOY_W   = 9;

  // Reciprocals for division by constants over 14-bit operands.
  localparam int RECIP_100 = 5243;   // floor(x/100) = (x * 5243) >> 19
  localparam int SHIFT_100 = 19;
  localparam int RECIP_7   = 18725;  // floor(x/7)   = (x * 18725) >> 17
  localparam int SHIFT_7   = 17;

  localparam logic [YEAR_W-1:0]  MAX_YEAR  = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [WDAY_W-1:0]  WD_SUN    = WDAY_W'(0);
  localparam logic [WDAY_W-1:0]  WD_SAT    = WDAY_W'(6);
  localparam logic [6:0]         LAST_YOC  = 7'd99;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL100,
    ST_SPLIT,
    ST_CHECK,
    ST_MUL7,
    ST_WDAY,
    ST_WALK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul100;
    logic split;
    logic check;
    logic mul7;
    logic wday;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic walk_done;
  } sts_t;

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
    logic [DAY_W-1:0] dim;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: dim = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    dim = DAY_W'(30);
      4'd2:    dim = leap ? DAY_W'(29) : DAY_W'(28);
      default: dim = DAY_W'(0);
    endcase
    return dim;
  endfunction

  // Days in the year before the first of the month, common year.
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] month);
    logic [DOY_W-1:0] cum;
    case (month)
      4'd1:    cum = DOY_W'(0);
      4'd2:    cum = DOY_W'(31);
      4'd3:    cum = DOY_W'(59);
      4'd4:    cum = DOY_W'(90);
      4'd5:    cum = DOY_W'(120);
      4'd6:    cum = DOY_W'(151);
      4'd7:    cum = DOY_W'(181);
      4'd8:    cum = DOY_W'(212);
      4'd9:    cum = DOY_W'(243);
      4'd10:   cum = DOY_W'(273);
      4'd11:   cum = DOY_W'(304);
      4'd12:   cum = DOY_W'(334);
      default: cum = DOY_W'(0);
    endcase
    return cum;
  endfunction

endpackage
`default_nettype wire

[rtl/wrd_if.sv]
// Interfaces: request and result channels of the return-date unit.
`default_nettype none
interface wrd_in_if;
  logic                       valid;
  logic                       ready;
  logic [wrd_pkg::YEAR_W-1:0]  start_year;
  logic [wrd_pkg::MONTH_W-1:0] start_month;
  logic [wrd_pkg::DAY_W-1:0]   start_day;
  logic [wrd_pkg::COUNT_W-1:0] vacation_days;

  modport source (output valid, start_year, start_month, start_day, vacation_days,
                  input ready);
  modport sink   (input valid, start_year, start_month, start_day, vacation_days,
                  output ready);
endinterface

interface wrd_out_if;
  logic                       valid;
  logic                       ready;
  logic [wrd_pkg::YEAR_W-1:0]  return_year;
  logic [wrd_pkg::MONTH_W-1:0] return_month;
  logic [wrd_pkg::DAY_W-1:0]   return_day;
  logic [wrd_pkg::WDAY_W-1:0]  return_weekday;
  logic                       date_invalid;

  modport source (output valid, return_year, return_month, return_day, return_weekday,
                  date_invalid, input ready);
  modport sink   (input valid, return_year, return_month, return_day, return_weekday,
                  date_invalid, output ready);
endinterface
`default_nettype wire

[rtl/workday_return_date_unit.sv]
// Top level: return date after a run of working days, Gregorian calendar.
// Usage
//   in_if  (sink)   : one transaction carries a start date and a count of
//                     working days. Taken only while the unit is idle.
//   out_if (source) : one transaction per request with the return date, its
//                     weekday (0 Sunday .. 6 Saturday) and date_invalid.
//                     A malformed start date (year 0 or above 9999, month
//                     outside 1..12, day outside the month) gives
//                     date_invalid = 1 with all date fields zero.
// Operation
//   The setup states MUL100, SPLIT, CHECK, MUL7 and WDAY resolve leap year
//   and start weekday through two constant-reciprocal multiplies. The walk
//   moves the date one day per cycle, about 1.4 calendar days per working
//   day plus up to two each for a weekend start and finish, until its stop
//   test passes; the emit state then loads the output register. A new
//   request is taken only once the previous one has been loaded there.
// Reset and stall
//   Synchronous active-low reset returns the controller to idle and drops
//   any pending result. A stalled receiver holds the result; the next
//   request is still taken and computed, and waits for the output register.
`default_nettype none
module workday_return_date_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wrd_in_if.sink     in_if,
  wrd_out_if.source  out_if
);

  wrd_pkg::cmd_t cmd;
  wrd_pkg::sts_t sts;

  // Sequence setup, walk and handoff.
  wrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the date cursor, leap counters and output register.
  wrd_datapath u_datapath (
    .clk            (clk),
    .start_year     (in_if.start_year),
    .start_month    (in_if.start_month),
    .start_day      (in_if.start_day),
    .vacation_days  (in_if.vacation_days),
    .cmd            (cmd),
    .sts            (sts),
    .return_year    (out_if.return_year),
    .return_month   (out_if.return_month),
    .return_day     (out_if.return_day),
    .return_weekday (out_if.return_weekday),
    .date_invalid   (out_if.date_invalid)
  );

  // An invalid result carries no date.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.date_invalid |->
      out_if.return_year == '0 && out_if.return_month == '0 &&
      out_if.return_day == '0 && out_if.return_weekday == '0)
    else $error("invalid result carries nonzero date");

  // A valid result always lands on Monday through Friday.
  a_weekday_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.date_invalid |->
      out_if.return_weekday >= 3'd1 && out_if.return_weekday <= 3'd5)
    else $error("return date falls on a weekend");

  // A valid result holds a month in 1..12 and a nonzero day.
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.date_invalid |->
      out_if.return_month >= 4'd1 && out_if.return_month <= 4'd12 &&
      out_if.return_day >= 5'd1)
    else $error("return date out of range");

  // Taking a request leaves the idle state.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("request taken while busy");

endmodule
`default_nettype wire

[rtl/wrd_ctrl.sv]
// Controller: state machine sequencing setup, the day walk and the result handoff.
`default_nettype none
module wrd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          out_ready,
  output logic               out_valid,
  input  wire wrd_pkg::sts_t sts,
  output wrd_pkg::cmd_t      cmd
);

  wrd_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            emit_ok;

  assign emit_ok   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wrd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wrd_pkg::ST_IDLE:   if (in_valid) state_nxt = wrd_pkg::ST_MUL100;
      wrd_pkg::ST_MUL100: state_nxt = wrd_pkg::ST_SPLIT;
      wrd_pkg::ST_SPLIT:  state_nxt = wrd_pkg::ST_CHECK;
      wrd_pkg::ST_CHECK:  state_nxt = wrd_pkg::ST_MUL7;
      wrd_pkg::ST_MUL7:   state_nxt = wrd_pkg::ST_WDAY;
      wrd_pkg::ST_WDAY:   state_nxt = wrd_pkg::ST_WALK;
      wrd_pkg::ST_WALK:   if (sts.invalid || sts.walk_done) state_nxt = wrd_pkg::ST_EMIT;
      wrd_pkg::ST_EMIT:   if (emit_ok) state_nxt = wrd_pkg::ST_IDLE;
      default:            state_nxt = wrd_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      wrd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      wrd_pkg::ST_MUL100: cmd.mul100 = 1'b1;
      wrd_pkg::ST_SPLIT:  cmd.split  = 1'b1;
      wrd_pkg::ST_CHECK:  cmd.check  = 1'b1;
      wrd_pkg::ST_MUL7:   cmd.mul7   = 1'b1;
      wrd_pkg::ST_WDAY:   cmd.wday   = 1'b1;
      wrd_pkg::ST_WALK:   cmd.step   = !(sts.invalid || sts.walk_done);
      wrd_pkg::ST_EMIT: begin
        if (emit_ok) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/wrd_datapath.sv]
// Datapath: date registers, leap counters, weekday arithmetic and output register.
`default_nettype none
module wrd_datapath (
  input  wire logic                        clk,
  input  wire logic [wrd_pkg::YEAR_W-1:0]  start_year,
  input  wire logic [wrd_pkg::MONTH_W-1:0] start_month,
  input  wire logic [wrd_pkg::DAY_W-1:0]   start_day,
  input  wire logic [wrd_pkg::COUNT_W-1:0] vacation_days,
  input  wire wrd_pkg::cmd_t               cmd,
  output wrd_pkg::sts_t                    sts,
  output logic [wrd_pkg::YEAR_W-1:0]       return_year,
  output logic [wrd_pkg::MONTH_W-1:0]      return_month,
  output logic [wrd_pkg::DAY_W-1:0]        return_day,
  output logic [wrd_pkg::WDAY_W-1:0]       return_weekday,
  output logic                             date_invalid
);

  localparam int YW = wrd_pkg::YEAR_W;
  localparam int MW = wrd_pkg::MONTH_W;
  localparam int DW = wrd_pkg::DAY_W;
  localparam int WW = wrd_pkg::WDAY_W;
  localparam int CW = wrd_pkg::COUNT_W;
  localparam int PW = wrd_pkg::PROD_W;

  logic [YW-1:0] year_r,  year_nxt;
  logic [MW-1:0] month_r, month_nxt;
  logic [DW-1:0] day_r,   day_nxt;
  logic [WW-1:0] wday_r,  wday_nxt;
  logic [CW-1:0] left_r,  left_nxt;
  logic [YW-1:0] pm1_r,   pm1_nxt;      // year minus one
  logic [PW-1:0] prod_r,  prod_nxt;
  logic [6:0]    q100_r,  q100_nxt;
  logic [1:0]    ym4_r,   ym4_nxt;      // year mod 4
  logic [6:0]    ym100_r, ym100_nxt;    // year mod 100
  logic [1:0]    yc4_r,   yc4_nxt;      // century mod 4
  logic          inv_r,   inv_nxt;
  logic [YW-1:0] sum_r,   sum_nxt;

  logic [YW-1:0] ret_year_r,  ret_year_nxt;
  logic [MW-1:0] ret_month_r, ret_month_nxt;
  logic [DW-1:0] ret_day_r,   ret_day_nxt;
  logic [WW-1:0] ret_wday_r,  ret_wday_nxt;
  logic          ret_inv_r,   ret_inv_nxt;

  logic [6:0]    q100;
  logic [6:0]    r100;
  logic [YW-1:0] r100_full;
  logic          leap;
  logic [DW-1:0] dim;
  logic          weekend;
  logic [11:0]   q7;
  logic [YW-1:0] r7_full;
  logic [YW-1:0] doy_sum;

  assign q100      = prod_r[wrd_pkg::SHIFT_100 +: 7];
  assign r100_full = pm1_r - YW'({7'd0, q100} * 14'd100);
  assign r100      = r100_full[6:0];
  assign leap      = (ym4_r == 2'd0) && ((ym100_r != 7'd0) || (yc4_r == 2'd0));
  assign dim       = wrd_pkg::days_in_month(month_r, leap);
  assign weekend   = (wday_r == wrd_pkg::WD_SUN) || (wday_r == wrd_pkg::WD_SAT);
  assign q7        = prod_r[wrd_pkg::SHIFT_7 +: 12];
  assign r7_full   = sum_r - YW'({2'd0, q7} * 14'd7);
  assign doy_sum   = YW'(wrd_pkg::days_before(month_r))
                   + YW'(leap && (month_r > wrd_pkg::MONTH_FEB))
                   + YW'(day_r);

  assign sts.invalid   = inv_r;
  assign sts.walk_done = !weekend && (left_r == '0);

  always_comb begin
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    wday_nxt  = wday_r;
    left_nxt  = left_r;
    pm1_nxt   = pm1_r;
    prod_nxt  = prod_r;
    q100_nxt  = q100_r;
    ym4_nxt   = ym4_r;
    ym100_nxt = ym100_r;
    yc4_nxt   = yc4_r;
    inv_nxt   = inv_r;
    sum_nxt   = sum_r;

    if (cmd.load) begin
      year_nxt  = start_year;
      month_nxt = start_month;
      day_nxt   = start_day;
      left_nxt  = vacation_days;
      pm1_nxt   = start_year - YW'(1);
    end
    if (cmd.mul100) begin
      prod_nxt = PW'(pm1_r) * PW'(wrd_pkg::RECIP_100);
    end
    if (cmd.split) begin
      // Shift year-minus-one residues forward by one year.
      q100_nxt  = q100;
      ym4_nxt   = year_r[1:0];
      ym100_nxt = (r100 == wrd_pkg::LAST_YOC) ? 7'd0 : r100 + 7'd1;
      yc4_nxt   = q100[1:0] + 2'(r100 == wrd_pkg::LAST_YOC);
    end
    if (cmd.check) begin
      inv_nxt = (year_r == '0) || (year_r > wrd_pkg::MAX_YEAR) ||
                (month_r == '0) || (month_r > wrd_pkg::MONTH_DEC) ||
                (day_r == '0) || (day_r > dim);
      // Monday-based count: p + p/4 - p/100 + p/400 + day of year (p*365 = p mod 7).
      sum_nxt = pm1_r + (pm1_r >> 2) - YW'(q100_r) + YW'(q100_r >> 2) + doy_sum;
    end
    if (cmd.mul7) begin
      prod_nxt = PW'(sum_r) * PW'(wrd_pkg::RECIP_7);
    end
    if (cmd.wday) begin
      wday_nxt = r7_full[WW-1:0];
    end
    if (cmd.step) begin
      if (!weekend) left_nxt = left_r - CW'(1);
      wday_nxt = (wday_r == wrd_pkg::WD_SAT) ? wrd_pkg::WD_SUN : wday_r + WW'(1);
      if (day_r >= dim) begin
        day_nxt = DW'(1);
        if (month_r == wrd_pkg::MONTH_DEC) begin
          month_nxt = MW'(1);
          year_nxt  = year_r + YW'(1);
          ym4_nxt   = ym4_r + 2'd1;
          if (ym100_r == wrd_pkg::LAST_YOC) begin
            ym100_nxt = 7'd0;
            yc4_nxt   = yc4_r + 2'd1;
          end else begin
            ym100_nxt = ym100_r + 7'd1;
          end
        end else begin
          month_nxt = month_r + MW'(1);
        end
      end else begin
        day_nxt = day_r + DW'(1);
      end
    end
  end

  always_comb begin
    ret_year_nxt  = ret_year_r;
    ret_month_nxt = ret_month_r;
    ret_day_nxt   = ret_day_r;
    ret_wday_nxt  = ret_wday_r;
    ret_inv_nxt   = ret_inv_r;
    if (cmd.emit) begin
      ret_year_nxt  = inv_r ? '0 : year_r;
      ret_month_nxt = inv_r ? '0 : month_r;
      ret_day_nxt   = inv_r ? '0 : day_r;
      ret_wday_nxt  = inv_r ? '0 : wday_r;
      ret_inv_nxt   = inv_r;
    end
  end

  always_ff @(posedge clk) begin
    year_r      <= year_nxt;
    month_r     <= month_nxt;
    day_r       <= day_nxt;
    wday_r      <= wday_nxt;
    left_r      <= left_nxt;
    pm1_r       <= pm1_nxt;
    prod_r      <= prod_nxt;
    q100_r      <= q100_nxt;
    ym4_r       <= ym4_nxt;
    ym100_r     <= ym100_nxt;
    yc4_r       <= yc4_nxt;
    inv_r       <= inv_nxt;
    sum_r       <= sum_nxt;
    ret_year_r  <= ret_year_nxt;
    ret_month_r <= ret_month_nxt;
    ret_day_r   <= ret_day_nxt;
    ret_wday_r  <= ret_wday_nxt;
    ret_inv_r   <= ret_inv_nxt;
  end

  assign return_year    = ret_year_r;
  assign return_month   = ret_month_r;
  assign return_day     = ret_day_r;
  assign return_weekday = ret_wday_r;
  assign date_invalid   = ret_inv_r;

endmodule
`default_nettype wire

[dv/tb_workday_return_date_unit.sv]
// Testbench for the return-date unit: directed table and random requests against a predictor.
`default_nettype none
module tb_workday_return_date_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import wrd_pkg::*;

  // Weekday codes used below, 0 is Sunday as on the result port.
  localparam logic [WDAY_W-1:0] WD_MON = WDAY_W'(1);
  localparam logic [WDAY_W-1:0] WD_FRI = WDAY_W'(5);
  localparam int DAYS_PER_ERA = 146097;
  localparam int N_ROWS = 25;
  localparam int ITEMS_PER_PHASE = 300;

  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [COUNT_W-1:0] vacation_days;
  } req_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  return_year;
    logic [MONTH_W-1:0] return_month;
    logic [DAY_W-1:0]   return_day;
    logic [WDAY_W-1:0]  return_weekday;
    logic               date_invalid;
  } result_t;

  // A directed row either carries its answer typed in or defers to the predictor.
  typedef struct packed {
    req_t    req;
    logic    pinned;
    result_t want;
  } date_row_t;

  typedef struct packed {
    logic    pinned;
    result_t want;
  } pin_t;

  localparam result_t MALFORMED = '{14'd0, 4'd0, 5'd0, 3'd0, 1'b1};

  logic clk = 1'b0;
  logic rst_n;

  wrd_in_if  in_bus();
  wrd_out_if out_bus();

  workday_return_date_unit u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_bus),
    .out_if(out_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Directed table: extremes of every field, each kind of malformed date,
  // weekend starts, a weekend crossing, month and year rollovers, leap days
  // under the century and 400-year rules, and the longest walks.
  date_row_t date_rows [N_ROWS] = '{
    '{'{14'd2024,  4'd1,  5'd1,  15'd0},     1'b1, '{14'd2024, 4'd1,  5'd1,  WD_MON, 1'b0}},
    '{'{14'd1,     4'd1,  5'd1,  15'd0},     1'b1, '{14'd1,    4'd1,  5'd1,  WD_MON, 1'b0}},
    '{'{14'd9999,  4'd12, 5'd31, 15'd0},     1'b1, '{14'd9999, 4'd12, 5'd31, WD_FRI, 1'b0}},
    '{'{14'd0,     4'd1,  5'd1,  15'd10},    1'b1, MALFORMED},
    '{'{14'd10000, 4'd1,  5'd1,  15'd3},     1'b1, MALFORMED},
    '{'{14'd16383, 4'd15, 5'd31, 15'd32767}, 1'b1, MALFORMED},
    '{'{14'd2024,  4'd0,  5'd10, 15'd1},     1'b1, MALFORMED},
    '{'{14'd2024,  4'd13, 5'd10, 15'd1},     1'b1, MALFORMED},
    '{'{14'd2024,  4'd5,  5'd0,  15'd1},     1'b1, MALFORMED},
    '{'{14'd2024,  4'd4,  5'd31, 15'd1},     1'b1, MALFORMED},
    '{'{14'd2023,  4'd2,  5'd29, 15'd1},     1'b1, MALFORMED},
    '{'{14'd1900,  4'd2,  5'd29, 15'd1},     1'b1, MALFORMED},
    '{'{14'd2000,  4'd2,  5'd29, 15'd5},     1'b0, '0},
    '{'{14'd2024,  4'd2,  5'd29, 15'd0},     1'b0, '0},
    '{'{14'd2024,  4'd1,  5'd6,  15'd0},     1'b0, '0},
    '{'{14'd2024,  4'd1,  5'd7,  15'd3},     1'b0, '0},
    '{'{14'd2024,  4'd1,  5'd5,  15'd1},     1'b0, '0},
    '{'{14'd2024,  4'd12, 5'd31, 15'd4},     1'b0, '0},
    '{'{14'd2023,  4'd2,  5'd28, 15'd1},     1'b0, '0},
    '{'{14'd9999,  4'd12, 5'd31, 15'd1},     1'b0, '0},
    '{'{14'd2024,  4'd1,  5'd31, 15'd7},     1'b0, '0},
    '{'{14'd2024,  4'd3,  5'd15, 15'd4},     1'b0, '0},
    '{'{14'd1582,  4'd10, 5'd4,  15'd10},    1'b0, '0},
    '{'{14'd1,     4'd1,  5'd1,  15'd16384}, 1'b0, '0},
    '{'{14'd9999,  4'd12, 5'd31, 15'd32767}, 1'b0, '0}
  };

  result_t return_dates_due [$];
  pin_t    pinned_answers [$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int requests_sent = 0;
  int returns_seen = 0;
  int malformed_seen = 0;
  int longest_walk = 0;
  int mismatches = 0;

  function automatic int month_length(input int m, input int y);
    logic leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Work out the first working day back. The walk is done in closed form
  // on a day count from 0000-03-01 (a Wednesday): five weekdays make a
  // week, and a remainder that runs past Friday jumps the weekend.
  function automatic result_t predict_return_date(input req_t r);
    int y, m, d, n, yy, era, yoe, doy, doe, mp, dn, wd, ry, rm, rd;
    result_t res;
    y = int'(r.start_year);
    m = int'(r.start_month);
    d = int'(r.start_day);
    n = int'(r.vacation_days);
    res = '0;
    if (y < 1 || y > int'(MAX_YEAR) || m < 1 || m > 12 || d < 1 ||
        d > month_length(m, y)) begin
      res.date_invalid = 1'b1;
      return res;
    end
    yy  = (m <= 2) ? y - 1 : y;
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m + 9) % 12;
    doy = (153 * mp + 2) / 5 + d - 1;
    dn  = era * DAYS_PER_ERA + yoe * 365 + yoe / 4 - yoe / 100 + doy;
    // Move a weekend start on to Monday.
    wd = (dn + 3) % 7;
    if (wd == int'(WD_SAT)) dn += 2;
    else if (wd == int'(WD_SUN)) dn += 1;
    wd = (dn + 3) % 7;
    dn += (n / 5) * 7 + n % 5;
    if (wd + n % 5 > 5) dn += 2;
    // Back to a calendar date.
    era = dn / DAYS_PER_ERA;
    doe = dn - era * DAYS_PER_ERA;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    rm  = (mp < 10) ? mp + 3 : mp - 9;
    rd  = doy - (153 * mp + 2) / 5 + 1;
    ry  = yoe + era * 400 + ((rm <= 2) ? 1 : 0);
    res.return_year    = YEAR_W'(ry);
    res.return_month   = MONTH_W'(rm);
    res.return_day     = DAY_W'(rd);
    res.return_weekday = WDAY_W'((dn + 3) % 7);
    return res;
  endfunction

  // Mostly well-formed dates with a bias toward leap-rule years and month
  // ends; a slice of raw noise on every date field. Walks mostly stay short,
  // some run to 511 days, and one slot in every 150 takes the full count range.
  function automatic req_t random_request(input int idx);
    req_t r;
    int y, m;
    if ($urandom_range(99) < 8) begin
      r.start_year  = YEAR_W'($urandom_range(16383));
      r.start_month = MONTH_W'($urandom);
      r.start_day   = DAY_W'($urandom);
    end else begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(7))
          0:       y = 1;
          1:       y = 4;
          2:       y = 100;
          3:       y = 400;
          4:       y = 1900;
          5:       y = 2000;
          6:       y = 2100;
          default: y = 9999;
        endcase
      end else begin
        y = int'($urandom_range(9999, 1));
      end
      m = int'($urandom_range(12, 1));
      r.start_year  = YEAR_W'(y);
      r.start_month = MONTH_W'(m);
      r.start_day   = ($urandom_range(3) == 0) ? DAY_W'(month_length(m, y))
                                               : DAY_W'($urandom_range(month_length(m, y), 1));
    end
    if (idx % 150 == 75)
      r.vacation_days = COUNT_W'($urandom_range(32767));
    else if ($urandom_range(99) < 13)
      r.vacation_days = COUNT_W'($urandom_range(511, 41));
    else
      r.vacation_days = COUNT_W'($urandom_range(40));
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Drive one request transaction; return at the edge that accepts it.
  // Valid stays high on return so back-to-back transactions need no gap.
  task automatic push_request(input req_t req, input logic pinned, input result_t want);
    pin_t entry;
    entry.pinned = pinned;
    entry.want   = want;
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pinned_answers.push_back(entry);
    in_bus.valid         <= 1'b1;
    in_bus.start_year    <= req.start_year;
    in_bus.start_month   <= req.start_month;
    in_bus.start_day     <= req.start_day;
    in_bus.vacation_days <= req.vacation_days;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    requests_sent++;
  endtask

  // Hold off the sender until every result already owed has come back.
  task automatic hold_until_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (returns_seen < requests_sent);
  endtask

  // Receiver: stall at the rate of the current phase.
  always @(posedge clk) out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);

  // Scoreboard: predict at request acceptance, compare at result acceptance.
  // Both run in one block so the order within an edge is fixed.
  always @(posedge clk) begin : scoreboard
    pin_t    pin;
    result_t guess;
    result_t due;
    req_t    req;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        req   = '{in_bus.start_year, in_bus.start_month, in_bus.start_day, in_bus.vacation_days};
        pin   = pinned_answers.pop_front();
        guess = predict_return_date(req);
        if (pin.pinned) guess = pin.want;
        if (guess.date_invalid) malformed_seen++;
        else if (int'(req.vacation_days) > longest_walk) longest_walk = int'(req.vacation_days);
        return_dates_due.push_back(guess);
      end
      if (out_bus.valid && out_bus.ready) begin
        returns_seen++;
        if (return_dates_due.size() == 0) begin
          $error("result transaction with no request outstanding");
          mismatches++;
        end else begin
          due = return_dates_due.pop_front();
          check_field("return_year",    32'(due.return_year),    32'(out_bus.return_year));
          check_field("return_month",   32'(due.return_month),   32'(out_bus.return_month));
          check_field("return_day",     32'(due.return_day),     32'(out_bus.return_day));
          check_field("return_weekday", 32'(due.return_weekday), 32'(out_bus.return_weekday));
          check_field("date_invalid",   32'(due.date_invalid),   32'(out_bus.date_invalid));
        end
      end
    end
  end

  // Main sequence: reset, directed table, three random phases with
  // different stall patterns, then drain and report.
  initial begin
    rst_n                <= 1'b0;
    in_bus.valid         <= 1'b0;
    in_bus.start_year    <= '0;
    in_bus.start_month   <= '0;
    in_bus.start_day     <= '0;
    in_bus.vacation_days <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows under the first phase's stall pattern.
    src_idle_pct = 8;
    snk_idle_pct = 81;
    for (int i = 0; i < N_ROWS; i++)
      push_request(date_rows[i].req, date_rows[i].pinned, date_rows[i].want);
    hold_until_drained();

    // Phase 0: receiver mostly stalled. Phase 1: sender mostly idle.
    // Phase 2: full rate on both sides.
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 81 : 0;
      snk_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 8 : 0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        push_request(random_request(k), 1'b0, '0);
      hold_until_drained();
    end

    // Allow for a stray result after the last expected one.
    repeat (100) @(posedge clk);
    if (return_dates_due.size() != 0) begin
      $error("%0d return dates never arrived", return_dates_due.size());
      mismatches++;
    end

    $display("Checked %0d return dates for %0d requests, %0d of them malformed start dates.",
             returns_seen, requests_sent, malformed_seen);
    $display("Longest walk %0d working days; stall mixes: receiver-heavy, sender-heavy, none.",
             longest_walk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: several times the slowest expected run.
  initial begin
    #100ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire

[workday_return_date_unit.f]
rtl/wrd_pkg.sv
rtl/wrd_if.sv
rtl/wrd_ctrl.sv
rtl/wrd_datapath.sv
rtl/workday_return_date_unit.sv
dv/tb_workday_return_date_unit.sv
